// ===== rtl/core/bgf_pkg.sv =====
package bgf_pkg;

  // One input frame.
  typedef struct packed {
    logic        in_present;
    logic [15:0] in_left;
    logic [15:0] in_top;
    logic [15:0] in_right;
    logic [15:0] in_bottom;
    logic        in_end;
  } bgf_in_t;

  // One emitted frame.
  typedef struct packed {
    logic        out_present;
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_right;
    logic [15:0] out_bottom;
    logic        out_filled;
    logic        out_overflow;
    logic        out_last;
  } bgf_out_t;

  // Sequencer to interpolation lane.
  typedef struct packed {
    logic start;
    logic advance;
  } bgf_lane_ctrl_t;

endpackage

// ===== rtl/core/bgf_in_if.sv =====
interface bgf_in_if;
  logic             valid;
  logic             ready;
  bgf_pkg::bgf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bgf_out_if.sv =====
interface bgf_out_if;
  logic              valid;
  logic              ready;
  bgf_pkg::bgf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bgf_lane.sv =====
// One coordinate: |next-prev| / gap by restoring division, then steps
// k*|diff|/gap incrementally as quotient/remainder pairs.
module bgf_lane #(
  parameter int CW = 16,
  parameter int GW = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bgf_pkg::bgf_lane_ctrl_t ctrl,
  input  logic [CW-1:0]           prev,
  input  logic [CW-1:0]           next,
  input  logic [GW-1:0]           gap,
  output logic [CW-1:0]           mid,
  output logic                    busy
);

  localparam int CNTW = $clog2(CW + 1);

  logic [CW-1:0]   base;
  logic            neg;
  logic [CW-1:0]   mag;
  logic [GW-1:0]   rem;
  logic [GW-1:0]   gap_r;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   quo_a;
  logic [GW-1:0]   rem_b;
  logic [CW-1:0]   acc_q;
  logic [GW-1:0]   acc_r;

  logic [CW-1:0] diff_mag;
  logic [GW:0]   trial;
  logic          qbit;
  logic [GW-1:0] rem_next;
  logic [CW-1:0] mag_next;
  logic [GW:0]   sum;

  always_comb begin
    diff_mag = (next >= prev) ? (next - prev) : (prev - next);
    trial    = {rem, mag[CW-1]};
    qbit     = (trial >= {1'b0, gap_r});
    rem_next = qbit ? GW'(trial - {1'b0, gap_r}) : trial[GW-1:0];
    mag_next = {mag[CW-2:0], qbit};
    sum      = {1'b0, acc_r} + {1'b0, rem_b};
    mid      = neg ? (base - acc_q) : (base + acc_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (ctrl.start) begin
        busy  <= 1'b1;
        cnt   <= CNTW'(CW);
        base  <= prev;
        neg   <= (next < prev);
        mag   <= diff_mag;
        rem   <= '0;
        gap_r <= gap;
      end else if (busy) begin
        mag <= mag_next;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy  <= 1'b0;
          quo_a <= mag_next;
          rem_b <= rem_next;
          acc_q <= mag_next;
          acc_r <= rem_next;
        end
      end else if (ctrl.advance) begin
        if (sum >= {1'b0, gap_r}) begin
          acc_r <= GW'(sum - {1'b0, gap_r});
          acc_q <= acc_q + quo_a + 1'b1;
        end else begin
          acc_r <= sum[GW-1:0];
          acc_q <= acc_q + quo_a;
        end
      end
    end
  end

endmodule

// ===== rtl/core/box_gap_linear_filler.sv =====
// Box gap filler for a stream of tracked bounding boxes.
// Input channel in_ch carries one frame per transaction: a present flag,
// four Q12.4 coordinates and an end-of-timeline mark. Output channel out_ch
// carries the emitted frames, out_last set on the final one caused by each
// input frame. Missing frames are only counted; they come out when the next
// measured box, a pending-limit overflow or an end mark releases them.
// One frame is handled at a time: in_ch.ready is high only while idle.
// A frame that releases frames puts one result per cycle into the output
// register while the receiver takes them, and frees the input once its last
// result is registered. Interpolation first runs four lanes of a restoring
// divider in parallel, one per coordinate, in the divide state; the lanes
// then step k*diff/gap by accumulate and compare, one per result.
// A counted missing frame only adds to the pending count and emits nothing.
// A stalled receiver holds the output register and pauses the run with it.
// Synchronous reset clears the timeline: no box seen, no frames pending.
module box_gap_linear_filler #(
  parameter int MAX_PENDING = 63,
  parameter int COORD_BITS  = 16
) (
  input logic      clk,
  input logic      rst,
  bgf_in_if.sink   in_ch,
  bgf_out_if.source out_ch
);

  localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int PW = $clog2(MAX_PENDING + 1);
  localparam int FW = $clog2(MAX_PENDING + 2);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;
  typedef enum logic [1:0] {K_COPY, K_INTERP, K_HOLD} kind_t;

  state_t state;
  kind_t  kind;
  logic   seen;
  logic [PW-1:0] pending;
  logic [3:0][CW-1:0] last_box;
  logic [FW-1:0] fill_left;
  logic   meas;
  logic   hold_present;
  logic   hold_ovf;
  logic   ovalid;
  bgf_pkg::bgf_out_t odata;

  logic [3:0][CW-1:0] box;
  logic [3:0][CW-1:0] mid;
  logic [3:0]         lane_busy;
  bgf_pkg::bgf_lane_ctrl_t lane_ctrl;
  logic accept;
  logic slot_free;
  logic gap_run;
  logic [CW-1:0] fill_coord [4];
  bgf_pkg::bgf_out_t fill_item;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !ovalid || out_ch.ready;
  assign gap_run   = in_ch.data.in_present && seen && (pending != '0);

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.data  = odata;

  always_comb begin
    box[0] = in_ch.data.in_left[CW-1:0];
    box[1] = in_ch.data.in_top[CW-1:0];
    box[2] = in_ch.data.in_right[CW-1:0];
    box[3] = in_ch.data.in_bottom[CW-1:0];
    lane_ctrl.start   = accept && gap_run;
    lane_ctrl.advance = (state == ST_EMIT) && slot_free && (fill_left != '0)
                        && (kind == K_INTERP);
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    bgf_lane #(.CW(CW), .GW(FW)) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl),
      .prev (last_box[c]),
      .next (box[c]),
      .gap  (FW'(pending) + 1'b1),
      .mid  (mid[c]),
      .busy (lane_busy[c])
    );
  end

  // Merge: pick each coordinate from the lanes or the stored box, or zero for an absent hold.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      case (kind)
        K_INTERP: fill_coord[c] = mid[c];
        K_HOLD:   fill_coord[c] = hold_present ? last_box[c] : '0;
        default:  fill_coord[c] = last_box[c];
      endcase
    end
    fill_item.out_present  = (kind == K_HOLD) ? hold_present : 1'b1;
    fill_item.out_left     = 16'(fill_coord[0]);
    fill_item.out_top      = 16'(fill_coord[1]);
    fill_item.out_right    = 16'(fill_coord[2]);
    fill_item.out_bottom   = 16'(fill_coord[3]);
    fill_item.out_filled   = (kind == K_HOLD) ? hold_present : 1'b1;
    fill_item.out_overflow = (kind == K_HOLD) && hold_ovf;
    fill_item.out_last     = (fill_left == FW'(1)) && !meas;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seen      <= 1'b0;
      pending   <= '0;
      ovalid    <= 1'b0;
      fill_left <= '0;
      meas      <= 1'b0;
    end else begin
      // the emit state refills the register itself when the slot frees
      if (ovalid && out_ch.ready && (state != ST_EMIT)) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.data.in_present) begin
              last_box  <= box;
              meas      <= 1'b1;
              fill_left <= FW'(pending);
              kind      <= seen ? K_INTERP : K_COPY;
              seen      <= !in_ch.data.in_end;
              pending   <= '0;
              state     <= gap_run ? ST_DIV : ST_EMIT;
            end else if (pending >= PW'(MAX_PENDING)) begin
              meas         <= 1'b0;
              fill_left    <= FW'(pending) + 1'b1;
              kind         <= K_HOLD;
              hold_present <= seen;
              hold_ovf     <= 1'b1;
              pending      <= '0;
              if (in_ch.data.in_end) begin
                seen <= 1'b0;
              end
              state <= ST_EMIT;
            end else if (in_ch.data.in_end) begin
              meas         <= 1'b0;
              fill_left    <= FW'(pending) + 1'b1;
              kind         <= K_HOLD;
              hold_present <= seen;
              hold_ovf     <= 1'b0;
              pending      <= '0;
              seen         <= 1'b0;
              state        <= ST_EMIT;
            end else begin
              pending <= pending + 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (lane_busy == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            ovalid <= 1'b1;
            if (fill_left != '0) begin
              odata     <= fill_item;
              fill_left <= fill_left - 1'b1;
              if (fill_item.out_last) begin
                state <= ST_IDLE;
              end
            end else begin
              odata.out_present  <= 1'b1;
              odata.out_left     <= 16'(last_box[0]);
              odata.out_top      <= 16'(last_box[1]);
              odata.out_right    <= 16'(last_box[2]);
              odata.out_bottom   <= 16'(last_box[3]);
              odata.out_filled   <= 1'b0;
              odata.out_overflow <= 1'b0;
              odata.out_last     <= 1'b1;
              meas               <= 1'b0;
              state              <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pending_limit: assert property (@(posedge clk) disable iff (rst)
    pending <= PW'(MAX_PENDING))
    else $error("pending count above limit");

  a_lanes_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && (kind == K_INTERP) && (fill_left != '0) |-> (lane_busy == '0))
    else $error("interpolated frame emitted while a lane is dividing");

  a_ovf_is_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && odata.out_overflow |-> (odata.out_present == odata.out_filled))
    else $error("overflow transaction is not a hold");

  a_seen_after_box: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.data.in_present && !in_ch.data.in_end |=> seen)
    else $error("measured box not recorded");

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (fill_left != '0) || meas)
    else $error("emit state with nothing left to send");

endmodule

// ===== dv/box_gap_linear_filler_tb.sv =====
module box_gap_linear_filler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_LIMIT    = 63;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 260;
  localparam int DRAIN_CYCLES = 100;

  typedef logic [3:0][15:0] box_t;  // [0] left, [1] top, [2] right, [3] bottom

  typedef struct {
    bgf_pkg::bgf_in_t  frame;
    int                reps;
    bit                typed;
    bgf_pkg::bgf_out_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bgf_in_if  in_ch ();
  bgf_out_if out_ch ();

  box_gap_linear_filler #(
    .MAX_PENDING(GAP_LIMIT),
    .COORD_BITS (16)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  bit                box_seen;
  box_t              held_box;
  int                gap_count;
  bgf_pkg::bgf_out_t frames_due[$];

  int error_count   = 0;
  int frames_checked = 0;
  int cycle_count   = 0;
  int stall_left    = 0;
  bit pressure_done = 1'b0;
  bit calm          = 1'b0;

  plan_row_t plan[$];

  function automatic bgf_pkg::bgf_in_t frm(bit p, logic [15:0] l, logic [15:0] t,
                                           logic [15:0] r, logic [15:0] b, bit e);
    bgf_pkg::bgf_in_t f;
    f.in_present = p;
    f.in_left    = l;
    f.in_top     = t;
    f.in_right   = r;
    f.in_bottom  = b;
    f.in_end     = e;
    return f;
  endfunction

  function automatic bgf_pkg::bgf_out_t emit(bit p, box_t bx, bit filled, bit ovf);
    bgf_pkg::bgf_out_t r;
    r = '0;
    r.out_present = p;
    if (p) begin
      r.out_left   = bx[0];
      r.out_top    = bx[1];
      r.out_right  = bx[2];
      r.out_bottom = bx[3];
    end
    r.out_filled   = filled;
    r.out_overflow = ovf;
    return r;
  endfunction

  // single-result rows: the transaction carries the last mark
  function automatic bgf_pkg::bgf_out_t res(bit p, logic [15:0] l, logic [15:0] t,
                                            logic [15:0] r, logic [15:0] b,
                                            bit filled, bit ovf);
    bgf_pkg::bgf_out_t o;
    o = emit(p, {b, r, t, l}, filled, ovf);
    o.out_last = 1'b1;
    return o;
  endfunction

  function automatic void release_holds(int cnt, bit ovf);
    int i;
    for (i = 0; i < cnt; i++) frames_due.push_back(emit(box_seen, held_box, box_seen, ovf));
  endfunction

  // Appends the frames released by one accepted input frame.
  function automatic void fill_gap_frames(bgf_pkg::bgf_in_t f);
    box_t              bx;
    box_t              mid;
    longint            diff;
    longint            q;
    int                n0;
    int                k;
    int                c;
    bgf_pkg::bgf_out_t tail;
    n0 = frames_due.size();
    bx = {f.in_bottom, f.in_right, f.in_top, f.in_left};
    if (f.in_present) begin
      if (!box_seen) begin
        for (k = 0; k < gap_count; k++) frames_due.push_back(emit(1'b1, bx, 1'b1, 1'b0));
      end else begin
        for (k = 1; k <= gap_count; k++) begin
          for (c = 0; c < 4; c++) begin
            diff   = longint'(bx[c]) - longint'(held_box[c]);
            q      = (diff * k) / (gap_count + 1);  // truncates toward zero
            mid[c] = 16'(longint'(held_box[c]) + q);
          end
          frames_due.push_back(emit(1'b1, mid, 1'b1, 1'b0));
        end
      end
      frames_due.push_back(emit(1'b1, bx, 1'b0, 1'b0));
      held_box  = bx;
      box_seen  = 1'b1;
      gap_count = 0;
    end else if (gap_count >= GAP_LIMIT) begin
      release_holds(gap_count + 1, 1'b1);
      gap_count = 0;
    end else begin
      gap_count++;
    end
    if (f.in_end) begin
      release_holds(gap_count, 1'b0);
      gap_count = 0;
      box_seen  = 1'b0;
    end
    if (frames_due.size() > n0) begin
      tail = frames_due.pop_back();
      tail.out_last = 1'b1;
      frames_due.push_back(tail);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_coord(logic [15:0] near);
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2, 3:    return 16'(near + $urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(bgf_pkg::bgf_in_t f, bit typed, bgf_pkg::bgf_out_t want);
    int idle;
    int n0;
    idle = pick_gap();
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= f;
    do @(posedge clk); while (!in_ch.ready);
    n0 = frames_due.size();
    fill_gap_frames(f);
    if (typed) begin
      while (frames_due.size() > n0) void'(frames_due.pop_back());
      frames_due.push_back(want);
    end
  endtask

  task automatic run_random(int budget);
    int                sent;
    int                gap_len;
    int                i;
    box_t              prev;
    bgf_pkg::bgf_in_t  f;
    bgf_pkg::bgf_out_t none;
    sent = 0;
    prev = '0;
    none = '0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      case ($urandom_range(0, 39))
        0:             gap_len = $urandom_range(60, 70);  // around the pending limit
        1, 2, 3, 4, 5: gap_len = $urandom_range(6, 30);
        default:       gap_len = $urandom_range(0, 5);
      endcase
      for (i = 0; i < gap_len; i++) begin
        f = frm(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(0, 39) == 0);
        send_frame(f, 1'b0, none);
        sent++;
      end
      // now and then the gap is left open
      if ($urandom_range(0, 9) != 0) begin
        f = frm(1'b1, pick_coord(prev[0]), pick_coord(prev[1]), pick_coord(prev[2]),
                pick_coord(prev[3]), $urandom_range(0, 9) == 0);
        prev = {f.in_bottom, f.in_right, f.in_top, f.in_left};
        send_frame(f, 1'b0, none);
        sent++;
      end
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // result checker and receiver back-pressure
  bgf_pkg::bgf_out_t oldest;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frames_due.size() == 0) begin
          $error("output transaction with nothing expected: %h", out_ch.data);
          error_count++;
        end else begin
          oldest = frames_due.pop_front();
          check_field("out_present",  oldest.out_present,  out_ch.data.out_present);
          check_field("out_left",     oldest.out_left,     out_ch.data.out_left);
          check_field("out_top",      oldest.out_top,      out_ch.data.out_top);
          check_field("out_right",    oldest.out_right,    out_ch.data.out_right);
          check_field("out_bottom",   oldest.out_bottom,   out_ch.data.out_bottom);
          check_field("out_filled",   oldest.out_filled,   out_ch.data.out_filled);
          check_field("out_overflow", oldest.out_overflow, out_ch.data.out_overflow);
          check_field("out_last",     oldest.out_last,     out_ch.data.out_last);
        end
        frames_checked++;
      end
      // one long hold-off so the block backs up into its input
      if (!pressure_done && frames_checked >= 120) begin
        pressure_done = 1'b1;
        stall_left    = 600;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    box_seen    = 1'b0;
    held_box    = '0;
    gap_count   = 0;

    // frame, reps, typed, expected
    plan.push_back('{frm(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0), 1, 1,
                     res(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0)});
    plan.push_back('{frm(1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0), 1, 1,
                     res(1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0)});
    // gap of 3, all coordinates falling
    plan.push_back('{frm(0, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 0), 2, 0, '0});
    plan.push_back('{frm(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0), 1, 0, '0});
    // gap of 2, all coordinates rising
    plan.push_back('{frm(0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0), 1, 0, '0});
    plan.push_back('{frm(1, 16'h0010, 16'h8000, 16'h00ff, 16'h7fff, 0), 1, 0, '0});
    // missing frame ending the timeline: one trailing hold
    plan.push_back('{frm(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1), 1, 0, '0});
    // fresh timeline, no box yet, end: absent frame
    plan.push_back('{frm(0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1), 1, 1,
                     res(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0)});
    // leading frames copy the first box
    plan.push_back('{frm(0, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0), 3, 0, '0});
    plan.push_back('{frm(1, 16'h0a0a, 16'h0b0b, 16'h0c0c, 16'h0d0d, 0), 1, 0, '0});
    plan.push_back('{frm(1, 16'h0a0b, 16'h0b0c, 16'h0c0d, 16'h0d0e, 1), 1, 1,
                     res(1, 16'h0a0b, 16'h0b0c, 16'h0c0d, 16'h0d0e, 0, 0)});
    // end with no box seen and frames pending: absent flush
    plan.push_back('{frm(0, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 0), 2, 0, '0});
    plan.push_back('{frm(0, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1), 1, 0, '0});
    // widest gap the limit allows, full-scale swing
    plan.push_back('{frm(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0), 1, 1,
                     res(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0)});
    plan.push_back('{frm(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0), GAP_LIMIT, 0, '0});
    plan.push_back('{frm(1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0), 1, 0, '0});
    // pending limit exceeded after a box: overflow holds, then trailing holds
    plan.push_back('{frm(0, 16'h4321, 16'h8765, 16'hcba9, 16'h0fed, 0), GAP_LIMIT + 1, 0, '0});
    plan.push_back('{frm(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0), 2, 0, '0});
    plan.push_back('{frm(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1), 1, 0, '0});
    // pending limit exceeded with no box: absent overflow frames
    plan.push_back('{frm(0, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 0), GAP_LIMIT + 1, 0, '0});
    plan.push_back('{frm(1, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1), 1, 1,
                     res(1, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 0, 0)});
    // gap of 6 with truncation in both directions
    plan.push_back('{frm(1, 16'h8000, 16'h0000, 16'hffff, 16'h1000, 0), 1, 1,
                     res(1, 16'h8000, 16'h0000, 16'hffff, 16'h1000, 0, 0)});
    plan.push_back('{frm(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0), 5, 0, '0});
    plan.push_back('{frm(1, 16'h7fff, 16'hffff, 16'h0000, 16'h1007, 0), 1, 0, '0});
    plan.push_back('{frm(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1), 1, 0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      repeat (plan[i].reps) send_frame(plan[i].frame, plan[i].typed, plan[i].want);
    end
    run_random(RANDOM_ITEMS);
    in_ch.valid <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
